// ----- src/assert_macros.svh -----
// assertion macros used by the rtl top level of the vertex and edge store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GGE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define GGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GGE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/gge_pkg.sv -----
// types, constants and helpers of the grid graph vertex and edge store
package gge_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int COORD_BITS    = 16;
    localparam int SLOT_BITS     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
    localparam int KIND_BITS     = 2;
    localparam int LINK_BITS     = 4;
    localparam int REQ_BITS      = 3;
    localparam int STATUS_BITS   = 3;
    localparam int SLOT_OUT_BITS = 6;
    localparam int ENTRY_BITS    = 2 * COORD_BITS + KIND_BITS + LINK_BITS;

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [KIND_BITS-1:0]     t_kind;
    typedef logic [LINK_BITS-1:0]     t_links;
    typedef logic [SLOT_BITS-1:0]     t_slot;
    typedef logic [CNT_BITS-1:0]      t_cnt;
    typedef logic [SLOT_OUT_BITS-1:0] t_slot_out;
    typedef logic [REQ_BITS-1:0]      t_req;
    typedef logic [STATUS_BITS-1:0]   t_status;

    // one table entry as held in the slot memory
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_kind  kind;
        t_links links;
    } t_entry;

    // result of the shared compare unit
    typedef struct packed {
        logic   eq_to;
        logic   eq_key2;
        t_links dir;
    } t_match;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ADD_VERTEX = 3'd0,
        REQ_ADD_EDGE   = 3'd1,
        REQ_REM_VERTEX = 3'd2,
        REQ_REM_EDGE   = 3'd3,
        REQ_CHG_KIND   = 3'd4,
        REQ_FIND       = 3'd5
    } t_req_e;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GOOD      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOT_ADJ   = 3'd3,
        ST_FULL      = 3'd4
    } t_status_e;

    // direction bits of the link field
    localparam t_links DIR_NONE = 4'b0000;
    localparam t_links DIR_XP   = 4'b0001;
    localparam t_links DIR_XM   = 4'b0010;
    localparam t_links DIR_YP   = 4'b0100;
    localparam t_links DIR_YM   = 4'b1000;

    // slot number onto the fixed-width result field
    function automatic t_slot_out slot_to_out(t_slot s);
        logic [SLOT_BITS+SLOT_OUT_BITS-1:0] w;
        w = (SLOT_BITS + SLOT_OUT_BITS)'(s);
        return w[SLOT_OUT_BITS-1:0];
    endfunction

endpackage

// ----- src/gge_req_if.sv -----
// request channel of the vertex and edge store
interface gge_req_if;
    import gge_pkg::*;

    logic   valid;
    logic   ready;
    t_req   req_type;
    t_coord first_x;
    t_coord first_y;
    t_coord second_x;
    t_coord second_y;
    t_kind  cell_kind;

    modport source (
        output valid, req_type, first_x, first_y, second_x, second_y, cell_kind,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_x, first_y, second_x, second_y, cell_kind,
        output ready
    );
endinterface

// ----- src/gge_rsp_if.sv -----
// response channel of the vertex and edge store
interface gge_rsp_if;
    import gge_pkg::*;

    logic      valid;
    logic      ready;
    t_status   status;
    t_slot_out slot_index;

    modport source (
        output valid, status, slot_index,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index,
        output ready
    );
endinterface

// ----- src/grid_graph_vertex_edge_store_top.sv -----
// top level of the grid graph vertex and edge store with its request sequencer
//
// Requests arrive on i_req (valid/ready): add vertex, add edge, remove vertex,
// remove edge, change type and find. Every request gives exactly one beat on
// o_rsp carrying a status and, for a successful find, the slot index.
// The table holds MAX_VERTICES slots in one ram; active flags sit in flops.
// Each request scans all slots through the ram read port, one slot a cycle,
// comparing each against both keys in the shared compare unit, then updates
// at most one entry; remove vertex instead runs a second scan that clears
// the links of every active slot that point at the removed vertex.
// One request is worked on at a time; i_req.ready is high only while idle,
// so a new request is taken only once the last one has passed its response
// to the output register.
// A finished response sits in an output register, so the next request is
// accepted while it waits; a stalled receiver holds the sequencer only once
// that next response is ready and the register is still full.
// Reset clears all active flags at once and drops any pending response;
// slot contents need no clearing since inactive slots are never matched.
`include "assert_macros.svh"

module grid_graph_vertex_edge_store_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gge_req_if.sink   i_req,
    gge_rsp_if.source o_rsp
);
    import gge_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_SCAN2,
        S_RESP
    } t_state;

    t_state            r_state;
    t_req              r_req_type;
    t_coord            r_x1;
    t_coord            r_y1;
    t_coord            r_x2;
    t_coord            r_y2;
    t_kind             r_kind;
    t_cnt              r_cnt;
    logic              r_pend;
    t_slot             r_pend_idx;
    logic              r_found_a;
    logic              r_found_b;
    t_slot             r_a_idx;
    t_entry            r_a_entry;
    logic              r_free_ok;
    t_slot             r_free_idx;
    logic [MAX_VERTICES-1:0] r_active;
    logic              r_wr_en;
    t_slot             r_wr_addr;
    t_entry            r_wr_data;
    t_status_e         r_res_status;
    t_slot_out         r_res_slot;
    logic              r_out_valid;
    t_status_e         r_out_status;
    t_slot_out         r_out_slot;

    logic              rd_en;
    t_slot             rd_addr;
    t_entry            rd_data;
    logic              scan_done;
    t_coord            m_from_x;
    t_coord            m_from_y;
    t_coord            m_to_x;
    t_coord            m_to_y;
    t_match            mt;

    // scan address and end of scan
    assign rd_en     = ((r_state == S_SCAN) || (r_state == S_SCAN2)) &&
                       (r_cnt != CNT_BITS'(MAX_VERTICES));
    assign rd_addr   = r_cnt[SLOT_BITS-1:0];
    assign scan_done = (r_cnt == CNT_BITS'(MAX_VERTICES)) && !r_pend;

    // slot memory
    gge_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // compare unit operands: edge direction while deciding, slot against keys otherwise
    always_comb begin
        if (r_state == S_EXEC) begin
            m_from_x = r_x1;
            m_from_y = r_y1;
            m_to_x   = r_x2;
            m_to_y   = r_y2;
        end else begin
            m_from_x = rd_data.x;
            m_from_y = rd_data.y;
            m_to_x   = r_x1;
            m_to_y   = r_y1;
        end
    end

    gge_match u_match (
        .i_from_x (m_from_x),
        .i_from_y (m_from_y),
        .i_to_x   (m_to_x),
        .i_to_y   (m_to_y),
        .i_key2_x (r_x2),
        .i_key2_y (r_y2),
        .o_match  (mt)
    );

    // channel outputs
    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.slot_index   = r_out_slot;

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_found_a   <= 1'b0;
            r_found_b   <= 1'b0;
            r_free_ok   <= 1'b0;
            r_active    <= '0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // read pipeline: the slot read this cycle is compared next cycle
            if (rd_en) begin
                r_cnt      <= r_cnt + CNT_BITS'(1);
                r_pend     <= 1'b1;
                r_pend_idx <= rd_addr;
            end else begin
                r_pend <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req_type <= i_req.req_type;
                        r_x1       <= i_req.first_x;
                        r_y1       <= i_req.first_y;
                        r_x2       <= i_req.second_x;
                        r_y2       <= i_req.second_y;
                        r_kind     <= i_req.cell_kind;
                        r_cnt      <= '0;
                        r_found_a  <= 1'b0;
                        r_found_b  <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // lowest free slot
                    if (rd_en && !r_active[rd_addr] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= rd_addr;
                    end
                    // first match of the source key, any match of the second key
                    if (r_pend && r_active[r_pend_idx]) begin
                        if (mt.eq_to && !r_found_a) begin
                            r_found_a <= 1'b1;
                            r_a_idx   <= r_pend_idx;
                            r_a_entry <= rd_data;
                        end
                        if (mt.eq_key2) begin
                            r_found_b <= 1'b1;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_status <= ST_GOOD;
                    r_res_slot   <= '0;
                    r_state      <= S_RESP;
                    case (r_req_type) inside
                        REQ_ADD_VERTEX: begin
                            if (r_found_a) begin
                                r_res_status <= ST_EXISTS;
                            end else if (!r_free_ok) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_wr_en              <= 1'b1;
                                r_wr_addr            <= r_free_idx;
                                r_wr_data.x          <= r_x1;
                                r_wr_data.y          <= r_y1;
                                r_wr_data.kind       <= r_kind;
                                r_wr_data.links      <= DIR_NONE;
                                r_active[r_free_idx] <= 1'b1;
                            end
                        end
                        REQ_ADD_EDGE, REQ_REM_EDGE: begin
                            r_wr_addr <= r_a_idx;
                            r_wr_data <= r_a_entry;
                            if (!r_found_a || !r_found_b) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else if (r_req_type == REQ_ADD_EDGE) begin
                                if (mt.dir == DIR_NONE) begin
                                    r_res_status <= ST_NOT_ADJ;
                                end else if ((r_a_entry.links & mt.dir) != DIR_NONE) begin
                                    r_res_status <= ST_EXISTS;
                                end else begin
                                    r_wr_en         <= 1'b1;
                                    r_wr_data.links <= r_a_entry.links | mt.dir;
                                end
                            end else begin
                                if ((r_a_entry.links & mt.dir) == DIR_NONE) begin
                                    r_res_status <= ST_NOT_FOUND;
                                end else begin
                                    r_wr_en         <= 1'b1;
                                    r_wr_data.links <= r_a_entry.links & ~mt.dir;
                                end
                            end
                        end
                        REQ_REM_VERTEX: begin
                            if (!r_found_a) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_active[r_a_idx] <= 1'b0;
                                r_cnt             <= '0;
                                r_state           <= S_SCAN2;
                            end
                        end
                        REQ_CHG_KIND: begin
                            if (!r_found_a) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_wr_en        <= 1'b1;
                                r_wr_addr      <= r_a_idx;
                                r_wr_data      <= r_a_entry;
                                r_wr_data.kind <= r_kind;
                            end
                        end
                        REQ_FIND: begin
                            if (!r_found_a) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_res_slot <= slot_to_out(r_a_idx);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_SCAN2: begin
                    // drop links that point at the removed vertex
                    if (r_pend && r_active[r_pend_idx] &&
                        ((rd_data.links & mt.dir) != DIR_NONE)) begin
                        r_wr_en         <= 1'b1;
                        r_wr_addr       <= r_pend_idx;
                        r_wr_data       <= rd_data;
                        r_wr_data.links <= rd_data.links & ~mt.dir;
                    end
                    if (scan_done) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks on the sequencer
    `GGE_ASSERT_IMPL(a_link_wr_active, i_clk, i_rst_n, (r_state == S_SCAN2) && r_wr_en, r_active[r_wr_addr], "link clear written to inactive slot")
    `GGE_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, rd_en && r_wr_en, rd_addr != r_wr_addr, "ram read and write hit the same slot")
    `GGE_ASSERT_IMPL(a_found_active, i_clk, i_rst_n, (r_state == S_EXEC) && r_found_a, r_active[r_a_idx], "matched slot is not active")
    `GGE_ASSERT_NEXT(a_rem_clears, i_clk, i_rst_n, (r_state == S_EXEC) && (r_req_type == REQ_REM_VERTEX) && r_found_a, !r_active[r_a_idx] && (r_state == S_SCAN2), "removed vertex still active")

endmodule

// ----- src/gge_ram.sv -----
// generic single write, single read ram with registered read data
module gge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/gge_match.sv -----
// shared compare unit: coordinate equality and grid direction
module gge_match (
    input  gge_pkg::t_coord i_from_x,
    input  gge_pkg::t_coord i_from_y,
    input  gge_pkg::t_coord i_to_x,
    input  gge_pkg::t_coord i_to_y,
    input  gge_pkg::t_coord i_key2_x,
    input  gge_pkg::t_coord i_key2_y,
    output gge_pkg::t_match o_match
);
    import gge_pkg::*;

    logic [COORD_BITS:0] from_x_p1;
    logic [COORD_BITS:0] from_y_p1;
    logic [COORD_BITS:0] to_x_p1;
    logic [COORD_BITS:0] to_y_p1;
    logic                same_x;
    logic                same_y;
    t_links              dir;

    // neighbour offsets in one extra bit so they never wrap
    assign from_x_p1 = {1'b0, i_from_x} + (COORD_BITS + 1)'(1);
    assign from_y_p1 = {1'b0, i_from_y} + (COORD_BITS + 1)'(1);
    assign to_x_p1   = {1'b0, i_to_x} + (COORD_BITS + 1)'(1);
    assign to_y_p1   = {1'b0, i_to_y} + (COORD_BITS + 1)'(1);
    assign same_x    = (i_from_x == i_to_x);
    assign same_y    = (i_from_y == i_to_y);

    // key equality
    assign o_match.eq_to   = same_x && same_y;
    assign o_match.eq_key2 = (i_from_x == i_key2_x) && (i_from_y == i_key2_y);
    assign o_match.dir     = dir;

    // direction from the first point to the second one
    always_comb begin
        dir = DIR_NONE;
        if (same_y) begin
            if ({1'b0, i_to_x} == from_x_p1) begin
                dir = DIR_XP;
            end else if ({1'b0, i_from_x} == to_x_p1) begin
                dir = DIR_XM;
            end
        end else if (same_x) begin
            if ({1'b0, i_to_y} == from_y_p1) begin
                dir = DIR_YP;
            end else if ({1'b0, i_from_y} == to_y_p1) begin
                dir = DIR_YM;
            end
        end
    end
endmodule

// ----- verif/grid_graph_vertex_edge_store_top_tb.sv -----
`timescale 1ns / 1ps
// testbench of the grid graph vertex and edge store: directed and random requests checked against a predictor
module grid_graph_vertex_edge_store_top_tb;
    import gge_pkg::*;

    // request codes that the block ignores
    localparam t_req REQ_SPARE_6 = 3'd6;
    localparam t_req REQ_SPARE_7 = 3'd7;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * MAX_VERTICES + 20;

    typedef enum int {PACE_NONE, PACE_LIGHT, PACE_HEAVY} t_pace;

    typedef struct packed {
        t_status   status;
        t_slot_out slot_index;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    gge_req_if req_if();
    gge_rsp_if rsp_if();

    grid_graph_vertex_edge_store_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted table contents
    logic   tbl_used  [MAX_VERTICES];
    t_coord tbl_x     [MAX_VERTICES];
    t_coord tbl_y     [MAX_VERTICES];
    t_kind  tbl_kind  [MAX_VERTICES];
    t_links tbl_links [MAX_VERTICES];

    t_answer answers_due[$];
    t_answer rsp_want;
    int      err_count;
    int      quiet_cycles;
    int      burst_left;
    int      stall_left;
    t_pace   sender_pace;
    t_pace   receiver_pace;
    t_coord  zone_x;
    t_coord  zone_y;
    int      zone_span;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // slot holding (x,y), or -1
    function automatic int locate_cell(t_coord x, t_coord y);
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (tbl_used[i] && tbl_x[i] == x && tbl_y[i] == y) begin
                return i;
            end
        end
        return -1;
    endfunction

    // link bit from one cell to the other, none unless orthogonal neighbours (no wrap)
    function automatic t_links step_toward(t_coord x1, t_coord y1, t_coord x2, t_coord y2);
        if (y1 == y2) begin
            if ({1'b0, x2} == {1'b0, x1} + 1'b1) return DIR_XP;
            if ({1'b0, x1} == {1'b0, x2} + 1'b1) return DIR_XM;
        end else if (x1 == x2) begin
            if ({1'b0, y2} == {1'b0, y1} + 1'b1) return DIR_YP;
            if ({1'b0, y1} == {1'b0, y2} + 1'b1) return DIR_YM;
        end
        return DIR_NONE;
    endfunction

    // apply one request to the predicted table and give its response
    function automatic t_answer predict_response(t_req req, t_coord x1, t_coord y1,
                                                 t_coord x2, t_coord y2, t_kind kind);
        t_answer ans;
        int      a;
        int      b;
        int      free_slot;
        t_links  d;
        ans.status     = ST_GOOD;
        ans.slot_index = '0;
        case (req)
            REQ_ADD_VERTEX: begin
                free_slot = -1;
                if (locate_cell(x1, y1) >= 0) begin
                    ans.status = ST_EXISTS;
                end else begin
                    // lowest free slot wins
                    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
                        if (!tbl_used[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        ans.status = ST_FULL;
                    end else begin
                        tbl_used[free_slot]  = 1'b1;
                        tbl_x[free_slot]     = x1;
                        tbl_y[free_slot]     = y1;
                        tbl_kind[free_slot]  = kind;
                        tbl_links[free_slot] = DIR_NONE;
                    end
                end
            end
            REQ_ADD_EDGE, REQ_REM_EDGE: begin
                a = locate_cell(x1, y1);
                b = locate_cell(x2, y2);
                d = step_toward(x1, y1, x2, y2);
                if (a < 0 || b < 0) begin
                    ans.status = ST_NOT_FOUND;
                end else if (req == REQ_ADD_EDGE) begin
                    if (d == DIR_NONE) ans.status = ST_NOT_ADJ;
                    else if ((tbl_links[a] & d) != DIR_NONE) ans.status = ST_EXISTS;
                    else tbl_links[a] = tbl_links[a] | d;
                end else if ((tbl_links[a] & d) == DIR_NONE) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    tbl_links[a] = tbl_links[a] & ~d;
                end
            end
            REQ_REM_VERTEX: begin
                a = locate_cell(x1, y1);
                if (a < 0) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    tbl_used[a]  = 1'b0;
                    tbl_links[a] = DIR_NONE;
                    // drop every link that points into the removed cell
                    for (int i = 0; i < MAX_VERTICES; i++) begin
                        if (tbl_used[i]) begin
                            tbl_links[i] = tbl_links[i] & ~step_toward(tbl_x[i], tbl_y[i], x1, y1);
                        end
                    end
                end
            end
            REQ_CHG_KIND: begin
                a = locate_cell(x1, y1);
                if (a < 0) ans.status = ST_NOT_FOUND;
                else tbl_kind[a] = kind;
            end
            REQ_FIND: begin
                a = locate_cell(x1, y1);
                if (a < 0) ans.status = ST_NOT_FOUND;
                else ans.slot_index = t_slot_out'(a);
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= 100) $display("%0t ns mismatch: %s", $time, what);
    endtask

    // one request beat, with bursts and gaps on the request side
    task automatic send_request(t_req req, t_coord x1, t_coord y1,
                                t_coord x2, t_coord y2, t_kind kind);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case (sender_pace)
                PACE_NONE:  gap = 0;
                PACE_LIGHT: gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 20);
                default:    gap = $urandom_range(0, 200);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        req_if.req_type  = req;
        req_if.first_x   = x1;
        req_if.first_y   = y1;
        req_if.second_x  = x2;
        req_if.second_y  = y2;
        req_if.cell_kind = kind;
        req_if.valid     = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        answers_due.push_back(predict_response(req, x1, y1, x2, y2, kind));
    endtask

    // start of a small random zone, often straddling zero or the top coordinate
    function automatic t_coord zone_base(int span);
        case ($urandom_range(0, 3))
            0:       return t_coord'(-(span / 2));
            1:       return t_coord'(-span);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic pick_cell(output t_coord x, output t_coord y);
        int s;
        // mostly an existing vertex, else a cell of the current zone
        if ($urandom_range(0, 9) < 6) begin
            for (int k = 0; k < 4; k++) begin
                s = $urandom_range(0, MAX_VERTICES - 1);
                if (tbl_used[s]) begin
                    x = tbl_x[s];
                    y = tbl_y[s];
                    return;
                end
            end
        end
        x = zone_x + t_coord'($urandom_range(0, zone_span - 1));
        y = zone_y + t_coord'($urandom_range(0, zone_span - 1));
    endtask

    // random requests with the given percentage mix, the remainder is noise
    task automatic run_random(int count, int w_add, int w_edge, int w_rem_edge,
                              int w_rem_vertex, int w_kind, int w_find);
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_req   req;
        int     roll;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                zone_span = $urandom_range(3, 12);
                zone_x    = zone_base(zone_span);
                zone_y    = zone_base(zone_span);
            end
            roll = $urandom_range(0, 99);
            pick_cell(x1, y1);
            x2 = t_coord'($urandom);
            y2 = t_coord'($urandom);
            if (roll < w_add) begin
                req = REQ_ADD_VERTEX;
                if ($urandom_range(0, 9) < 8) begin
                    x1 = zone_x + t_coord'($urandom_range(0, zone_span - 1));
                    y1 = zone_y + t_coord'($urandom_range(0, zone_span - 1));
                end
            end else if (roll < w_add + w_edge + w_rem_edge) begin
                req = (roll < w_add + w_edge) ? REQ_ADD_EDGE : REQ_REM_EDGE;
                // destination: mostly a neighbour, sometimes itself or anywhere
                roll = $urandom_range(0, 19);
                if (roll < 15) begin
                    x2 = x1;
                    y2 = y1;
                    case ($urandom_range(0, 3))
                        0:       x2 = x1 + 16'd1;
                        1:       x2 = x1 - 16'd1;
                        2:       y2 = y1 + 16'd1;
                        default: y2 = y1 - 16'd1;
                    endcase
                end else if (roll < 17) begin
                    x2 = x1;
                    y2 = y1;
                end else begin
                    pick_cell(x2, y2);
                end
            end else if (roll < w_add + w_edge + w_rem_edge + w_rem_vertex) begin
                req = REQ_REM_VERTEX;
            end else if (roll < w_add + w_edge + w_rem_edge + w_rem_vertex + w_kind) begin
                req = REQ_CHG_KIND;
            end else if (roll < w_add + w_edge + w_rem_edge + w_rem_vertex + w_kind + w_find) begin
                req = REQ_FIND;
            end else begin
                // noise: spare codes or anything at random coordinates
                if ($urandom_range(0, 1) == 0) begin
                    req = ($urandom_range(0, 1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
                end else begin
                    req = t_req'($urandom_range(0, 7));
                end
                x1 = t_coord'($urandom);
                y1 = t_coord'($urandom);
            end
            send_request(req, x1, y1, x2, y2, t_kind'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_vertex_requests();
        sender_pace   = PACE_LIGHT;
        receiver_pace = PACE_LIGHT;
        send_request(REQ_FIND, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd3);
        send_request(REQ_ADD_VERTEX, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd0);
        // duplicate cell
        send_request(REQ_ADD_VERTEX, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd3);
        send_request(REQ_ADD_VERTEX, 16'h0001, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd1);
        send_request(REQ_ADD_VERTEX, 16'h0000, 16'h0001, t_coord'($urandom), t_coord'($urandom), 2'd2);
        send_request(REQ_ADD_VERTEX, 16'hFFFF, 16'hFFFF, t_coord'($urandom), t_coord'($urandom), 2'd3);
        send_request(REQ_ADD_VERTEX, 16'hFFFE, 16'hFFFF, t_coord'($urandom), t_coord'($urandom), 2'd1);
        send_request(REQ_ADD_VERTEX, 16'h0000, 16'hFFFF, t_coord'($urandom), t_coord'($urandom), 2'd0);
        send_request(REQ_CHG_KIND, 16'h0000, 16'h0001, t_coord'($urandom), t_coord'($urandom), 2'd3);
        send_request(REQ_CHG_KIND, 16'h0005, 16'h0005, t_coord'($urandom), t_coord'($urandom), 2'd2);
        send_request(REQ_FIND, 16'hFFFF, 16'hFFFF, t_coord'($urandom), t_coord'($urandom), 2'd0);
    endtask

    task automatic test_edge_requests();
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 2'd1);
        // duplicate edge, self edge, distant edge
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 2'd2);
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd3);
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 2'd0);
        // neighbours across the coordinate wrap are not adjacent
        send_request(REQ_ADD_EDGE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 2'd1);
        // missing destination, then missing source
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'h0005, 16'h0005, 2'd2);
        send_request(REQ_ADD_EDGE, 16'h0007, 16'h0007, 16'h0000, 16'h0000, 2'd3);
        send_request(REQ_ADD_EDGE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 2'd0);
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 2'd1);
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 2'd2);
        send_request(REQ_REM_EDGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd3);
        send_request(REQ_REM_EDGE, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 2'd0);
    endtask

    task automatic test_vertex_removal();
        // inbound link from (0,1) must go with the cell
        send_request(REQ_REM_VERTEX, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd1);
        send_request(REQ_REM_VERTEX, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd2);
        send_request(REQ_ADD_VERTEX, 16'h0000, 16'h0000, t_coord'($urandom), t_coord'($urandom), 2'd2);
        send_request(REQ_ADD_EDGE, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 2'd3);
    endtask

    task automatic test_spare_codes();
        send_request(REQ_SPARE_6, t_coord'($urandom), t_coord'($urandom),
                     t_coord'($urandom), t_coord'($urandom), 2'd1);
        send_request(REQ_SPARE_7, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 2'd2);
    endtask

    task automatic test_random_mixed();
        sender_pace   = PACE_LIGHT;
        receiver_pace = PACE_LIGHT;
        run_random(350, 30, 25, 10, 8, 7, 15);
    endtask

    task automatic test_random_fill();
        // add-heavy so the table runs full
        sender_pace   = PACE_HEAVY;
        receiver_pace = PACE_HEAVY;
        run_random(450, 60, 15, 5, 3, 5, 10);
    endtask

    task automatic test_back_to_back();
        sender_pace   = PACE_NONE;
        receiver_pace = PACE_NONE;
        run_random(250, 25, 25, 12, 10, 8, 15);
    endtask

    task automatic test_random_churn();
        sender_pace   = PACE_HEAVY;
        receiver_pace = PACE_LIGHT;
        run_random(450, 25, 20, 10, 25, 5, 12);
    endtask

    // response stall pattern
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            case (receiver_pace)
                PACE_NONE: begin
                    rsp_if.ready = 1'b1;
                end
                PACE_LIGHT: begin
                    rsp_if.ready = ~rsp_if.ready;
                    stall_left   = rsp_if.ready ? $urandom_range(0, 19) : $urandom_range(0, 7);
                end
                default: begin
                    rsp_if.ready = ~rsp_if.ready;
                    stall_left   = rsp_if.ready ? $urandom_range(0, 9) : $urandom_range(0, 149);
                end
            endcase
        end
    end

    // response check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("response beat with none expected: status %0d slot %0d",
                                          rsp_if.status, rsp_if.slot_index));
            end else begin
                rsp_want = answers_due.pop_front();
                if (rsp_if.status !== rsp_want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, rsp_want.status));
                end
                if (rsp_if.slot_index !== rsp_want.slot_index) begin
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              rsp_if.slot_index, rsp_want.slot_index));
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("grid_graph_vertex_edge_store_top_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_ADD_VERTEX;
        req_if.first_x   = '0;
        req_if.first_y   = '0;
        req_if.second_x  = '0;
        req_if.second_y  = '0;
        req_if.cell_kind = '0;
        rsp_if.ready     = 1'b0;
        err_count        = 0;
        quiet_cycles     = 0;
        burst_left       = 0;
        stall_left       = 0;
        sender_pace      = PACE_LIGHT;
        receiver_pace    = PACE_LIGHT;
        zone_x           = '0;
        zone_y           = '0;
        zone_span        = 4;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_x[i]     = '0;
            tbl_y[i]     = '0;
            tbl_kind[i]  = '0;
            tbl_links[i] = DIR_NONE;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_vertex_requests();
        test_edge_requests();
        test_vertex_removal();
        test_spare_codes();
        test_random_mixed();
        test_random_fill();
        test_back_to_back();
        test_random_churn();

        // let the last responses drain
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("grid_graph_vertex_edge_store_top_tb: done, clean");
        end else begin
            $display("grid_graph_vertex_edge_store_top_tb: done, errors");
        end
        $finish;
    end

endmodule
